// ===== rtl/ultrasonic_echo_ranger_core_macros.svh =====
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger assertion macros
// Shared property wrappers for the ranger's concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef ULTRASONIC_ECHO_RANGER_CORE_MACROS_SVH
`define ULTRASONIC_ECHO_RANGER_CORE_MACROS_SVH

// Checked on every rising edge of clk, ignored while reset is asserted.
`define UER_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising edge of clk, including during reset.
`define UER_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/uer_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger package
// Payload types, register indexes and constants shared by the ranger modules.
// ----------------------------------------------------------------------------
package uer_pkg;

	localparam int COUNT_BITS_DEF = 13;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_TICKS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_COUNT     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Q16     = 2'd2;

	localparam logic [7:0]  TRIGGER_TICKS_RST = 8'd10;
	localparam logic [12:0] MAX_COUNT_RST     = 13'd7500;
	localparam logic [15:0] SCALE_Q16_RST     = 16'd22282;

	localparam logic [9:0] DIST_MAX = 10'd999;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_TRIG  = 2'd1,
		PH_WAIT  = 2'd2,
		PH_COUNT = 2'd3
	} phase_t;

	typedef struct packed {
		logic start_req;
		logic echo;
	} in_t;

	typedef struct packed {
		logic       trigger;
		logic       done_res;
		logic [9:0] dist_value;
		logic [3:0] digit_units;
		logic [3:0] digit_tens;
		logic [3:0] digit_hundreds;
		logic       over_range;
		logic       busy_res;
	} out_t;

	// Per-tick control flags carried down the pipeline.
	typedef struct packed {
		logic trig;
		logic done;
		logic busy;
	} ctl_t;

	// Load strobes for the three pipeline registers.
	typedef struct packed {
		logic ld_s1;
		logic ld_s2;
		logic ld_out;
	} adv_t;

endpackage

// ===== rtl/ultrasonic_echo_ranger_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger core
// Times an echo pulse in microsecond ticks and reports distance and digits.
// ----------------------------------------------------------------------------
// Each transaction on the input channel is one tick and yields exactly one
// result transaction. A tick is taken every clock cycle while the output is
// not stalled; its result passes in order through the control stage (state
// machine and tick counter), the product register of the count times
// scale_q16 multiply, and the output register where the distance is
// saturated and split into digits. Distance fields hold the last
// measurement until done_res marks a new one. Configuration writes are always
// ready and should be made only while the core is idle.
`include "ultrasonic_echo_ranger_core_macros.svh"

module ultrasonic_echo_ranger_core #(
	parameter int COUNT_BITS = uer_pkg::COUNT_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  uer_pkg::in_t                       in_data,
	output logic                               out_valid,
	input  logic                               out_stall,
	output uer_pkg::out_t                      out_data,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [uer_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [uer_pkg::CFG_DATA_W-1:0]     cfg_data
);

	logic [7:0]            trigger_ticks_q;
	logic [12:0]           max_count_q;
	logic [15:0]           scale_q16_q;
	logic                  valid_s1, valid_s2, out_valid_q;
	logic                  en1, en2, en_out;
	logic                  accept;
	uer_pkg::adv_t         adv;
	uer_pkg::ctl_t         ctl_s1;
	logic [COUNT_BITS-1:0] count_s1;
	logic [11:0]           digit_sum;
	logic                  sat_dist;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trigger_ticks_q <= uer_pkg::TRIGGER_TICKS_RST;
			max_count_q     <= uer_pkg::MAX_COUNT_RST;
			scale_q16_q     <= uer_pkg::SCALE_Q16_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				uer_pkg::CFG_TRIGGER_TICKS: trigger_ticks_q <= cfg_data[7:0];
				uer_pkg::CFG_MAX_COUNT:     max_count_q     <= cfg_data[12:0];
				uer_pkg::CFG_SCALE_Q16:     scale_q16_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// A stage moves forward when it is empty or the stage after it moves.
	assign en_out   = !out_valid_q || !out_stall;
	assign en2      = !valid_s2 || en_out;
	assign en1      = !valid_s1 || en2;
	assign in_stall = !en1;
	assign accept   = in_valid && en1;

	assign adv.ld_s1  = en1;
	assign adv.ld_s2  = en2;
	assign adv.ld_out = en_out && valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en1) begin
				valid_s1 <= in_valid;
			end
			if (en2) begin
				valid_s2 <= valid_s1;
			end
			if (en_out) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	assign out_valid = out_valid_q;

	uer_ctrl #(
		.COUNT_BITS(COUNT_BITS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.item         (in_data),
		.trigger_ticks(trigger_ticks_q),
		.max_count    (max_count_q),
		.adv          (adv),
		.ctl_s1       (ctl_s1),
		.count_s1     (count_s1)
	);

	uer_scale #(
		.COUNT_BITS(COUNT_BITS)
	) u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.ctl_s1   (ctl_s1),
		.count_s1 (count_s1),
		.scale_q16(scale_q16_q),
		.result   (out_data)
	);

	assign digit_sum = 12'(out_data.digit_hundreds) * 12'd100
		+ 12'(out_data.digit_tens) * 12'd10 + 12'(out_data.digit_units);
	assign sat_dist  = (out_data.dist_value == uer_pkg::DIST_MAX);

	`UER_ASSERT(a_digits_match, out_valid |-> (digit_sum == 12'(out_data.dist_value)), "digits disagree")
	`UER_ASSERT(a_over_sat, out_valid && out_data.over_range |-> sat_dist, "over range unsaturated")
	`UER_ASSERT(a_done_idle, out_valid && out_data.done_res |-> !out_data.busy_res, "busy when done")
	`UER_ASSERT_ALWAYS(a_stall_full, in_stall |-> (out_valid_q && out_stall), "stall with room")

endmodule

// ===== rtl/uer_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger control
// Measurement state machine and tick counter, one tick per transaction.
// ----------------------------------------------------------------------------
module uer_ctrl #(
	parameter int COUNT_BITS = uer_pkg::COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  uer_pkg::in_t          item,
	input  logic [7:0]            trigger_ticks,
	input  logic [12:0]           max_count,
	input  uer_pkg::adv_t         adv,
	output uer_pkg::ctl_t         ctl_s1,
	output logic [COUNT_BITS-1:0] count_s1
);

	localparam logic [16:0] CAP = 17'((1 << COUNT_BITS) - 1);

	uer_pkg::phase_t       phase_q, phase_d;
	logic [COUNT_BITS-1:0] tick_count_q, tick_count_d;
	logic [16:0]           lim_w;
	logic [COUNT_BITS-1:0] lim;
	logic [COUNT_BITS-1:0] cnt_base, cnt_inc;
	logic                  cnt_end;
	logic [COUNT_BITS-1:0] trig_next;
	logic                  trig_end;
	uer_pkg::ctl_t         ctl_d;
	logic [COUNT_BITS-1:0] count_d;

	// The count limit is max_count clipped to what the counter can hold.
	assign lim_w = (17'(max_count) < CAP) ? 17'(max_count) : CAP;
	assign lim   = lim_w[COUNT_BITS-1:0];

	// The first echo-high tick restarts the count from zero.
	assign cnt_base = (phase_q == uer_pkg::PH_WAIT) ? '0 : tick_count_q;
	assign cnt_inc  = (cnt_base < lim) ? cnt_base + COUNT_BITS'(1) : cnt_base;
	assign cnt_end  = (cnt_inc >= lim);

	// A trigger length of zero behaves as one tick.
	assign trig_next = tick_count_q + COUNT_BITS'(1);
	assign trig_end  = (trig_next >= COUNT_BITS'(trigger_ticks));

	always_comb begin
		phase_d      = phase_q;
		tick_count_d = tick_count_q;
		case (phase_q)
			uer_pkg::PH_IDLE: begin
				if (item.start_req) begin
					phase_d      = uer_pkg::PH_TRIG;
					tick_count_d = '0;
				end
			end
			uer_pkg::PH_TRIG: begin
				tick_count_d = trig_next;
				if (trig_end) begin
					phase_d      = uer_pkg::PH_WAIT;
					tick_count_d = '0;
				end
			end
			uer_pkg::PH_WAIT: begin
				if (item.echo) begin
					phase_d      = cnt_end ? uer_pkg::PH_IDLE : uer_pkg::PH_COUNT;
					tick_count_d = cnt_end ? '0 : cnt_inc;
				end
			end
			uer_pkg::PH_COUNT: begin
				if (item.echo && !cnt_end) begin
					tick_count_d = cnt_inc;
				end else begin
					phase_d      = uer_pkg::PH_IDLE;
					tick_count_d = '0;
				end
			end
			default: begin
				phase_d      = uer_pkg::PH_IDLE;
				tick_count_d = '0;
			end
		endcase
	end

	always_comb begin
		ctl_d.trig = 1'b0;
		ctl_d.done = 1'b0;
		count_d    = cnt_inc;
		case (phase_q)
			uer_pkg::PH_IDLE: begin
				ctl_d.done = 1'b0;
			end
			uer_pkg::PH_TRIG: begin
				ctl_d.trig = 1'b1;
			end
			uer_pkg::PH_WAIT: begin
				ctl_d.done = item.echo && cnt_end;
			end
			uer_pkg::PH_COUNT: begin
				ctl_d.done = !item.echo || cnt_end;
				// A low echo ends the measurement without adding to the count.
				count_d    = item.echo ? cnt_inc : tick_count_q;
			end
			default: begin
				ctl_d.done = 1'b0;
			end
		endcase
		ctl_d.busy = (phase_d != uer_pkg::PH_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= uer_pkg::PH_IDLE;
			tick_count_q <= '0;
		end else if (accept) begin
			phase_q      <= phase_d;
			tick_count_q <= tick_count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv.ld_s1) begin
			ctl_s1   <= ctl_d;
			count_s1 <= count_d;
		end
	end

endmodule

// ===== rtl/uer_scale.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger scaling
// Count to distance product, saturation, decimal split and result register.
// ----------------------------------------------------------------------------
module uer_scale #(
	parameter int COUNT_BITS = uer_pkg::COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  uer_pkg::adv_t         adv,
	input  uer_pkg::ctl_t         ctl_s1,
	input  logic [COUNT_BITS-1:0] count_s1,
	input  logic [15:0]           scale_q16,
	output uer_pkg::out_t         result
);

	localparam int PW = COUNT_BITS + 16;

	uer_pkg::ctl_t   ctl_s2;
	logic [PW-1:0]   prod_s2;
	logic [16:0]     dist_w;
	logic            over;
	logic [9:0]      dist_sat;
	logic [15:0]     hund_p;
	logic [3:0]      hund;
	logic [6:0]      rem;
	logic [14:0]     tens_p;
	logic [3:0]      tens;
	logic [3:0]      units;
	uer_pkg::out_t   result_q;

	always_ff @(posedge clk) begin
		if (adv.ld_s2) begin
			ctl_s2  <= ctl_s1;
			prod_s2 <= PW'(count_s1) * PW'(scale_q16);
		end
	end

	// Drop the Q16 fraction, then clamp to three digits.
	assign dist_w   = 17'(prod_s2[PW-1:16]);
	assign over     = (dist_w > 17'(uer_pkg::DIST_MAX));
	assign dist_sat = over ? uer_pkg::DIST_MAX : dist_w[9:0];

	// Reciprocal multiplies: x*41>>12 is x/100 and x*205>>11 is x/10 in range.
	assign hund_p = 16'(dist_sat) * 16'd41;
	assign hund   = hund_p[15:12];
	assign rem    = 7'(dist_sat - 10'(hund) * 10'd100);
	assign tens_p = 15'(rem) * 15'd205;
	assign tens   = tens_p[14:11];
	assign units  = 4'(rem - 7'(tens) * 7'd10);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_q <= '0;
		end else if (adv.ld_out) begin
			result_q.trigger  <= ctl_s2.trig;
			result_q.done_res <= ctl_s2.done;
			result_q.busy_res <= ctl_s2.busy;
			if (ctl_s2.done) begin
				result_q.dist_value     <= dist_sat;
				result_q.digit_units    <= units;
				result_q.digit_tens     <= tens;
				result_q.digit_hundreds <= hund;
				result_q.over_range     <= over;
			end
		end
	end

	assign result = result_q;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger core testbench
// Drives echo ticks into the ranger and checks every result tick against a
// cycle-free behavioral predictor of the trigger, wait and count sequence,
// with random idle cycles on both sides and a long output hold-off.
// ----------------------------------------------------------------------------
module tb;

	localparam int          CYCLE_LIMIT  = 400000;
	localparam int          HOLD_CYCLES  = 150;
	localparam int          PIPE_LATENCY = 3;
	localparam int          DRAIN_LIMIT  = 4000;
	localparam int          RANDOM_TICKS = 420;
	localparam int unsigned COUNT_CAP    = (1 << uer_pkg::COUNT_BITS_DEF) - 1;
	localparam logic [uer_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

	logic                           clk;
	logic                           arst_n;
	logic                           in_valid;
	logic                           in_stall;
	uer_pkg::in_t                   in_data;
	logic                           out_valid;
	logic                           out_stall;
	uer_pkg::out_t                  out_data;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [uer_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [uer_pkg::CFG_DATA_W-1:0] cfg_data;

	// Predicted state, updated per accepted transaction, and register copies, updated per config write.
	uer_pkg::phase_t m_phase     = uer_pkg::PH_IDLE;
	int unsigned     m_ticks     = 0;
	logic [9:0]      m_dist      = '0;
	logic            m_over      = 1'b0;
	logic [7:0]      m_trig_len  = uer_pkg::TRIGGER_TICKS_RST;
	logic [12:0]     m_max_count = uer_pkg::MAX_COUNT_RST;
	logic [15:0]     m_scale     = uer_pkg::SCALE_Q16_RST;

	uer_pkg::out_t pending_outputs[$];
	int   error_count = 0;
	int   live_ticks  = 0;
	bit   gaps_on     = 1'b1;
	bit   stalls_on   = 1'b1;
	bit   hold_req    = 1'b0;

	ultrasonic_echo_ranger_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic report_error(input string msg);
		if (error_count < 40)
			$display("%0t ERROR %s", $time, msg);
		error_count++;
	endtask

	function automatic void latch_distance(input int unsigned count);
		longint unsigned d;
		d = (64'(count) * 64'(m_scale)) >> 16;
		if (d > uer_pkg::DIST_MAX) begin
			m_dist = uer_pkg::DIST_MAX;
			m_over = 1'b1;
		end else begin
			m_dist = d[9:0];
			m_over = 1'b0;
		end
		m_phase = uer_pkg::PH_IDLE;
		m_ticks = 0;
	endfunction

	// One tick with echo high while counting; returns 1 when the count ends.
	function automatic bit echo_high_tick();
		int unsigned lim;
		lim = (m_max_count < COUNT_CAP) ? m_max_count : COUNT_CAP;
		if (m_ticks < lim)
			m_ticks++;
		if (m_ticks >= lim) begin
			latch_distance(m_ticks);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic uer_pkg::out_t next_ranger_outputs(input uer_pkg::in_t tick);
		uer_pkg::out_t r;
		r = '0;
		case (m_phase)
			uer_pkg::PH_IDLE: begin
				if (tick.start_req) begin
					m_phase = uer_pkg::PH_TRIG;
					m_ticks = 0;
				end
			end
			uer_pkg::PH_TRIG: begin
				r.trigger = 1'b1;
				m_ticks++;
				if (m_ticks >= m_trig_len) begin
					m_phase = uer_pkg::PH_WAIT;
					m_ticks = 0;
				end
			end
			uer_pkg::PH_WAIT: begin
				if (tick.echo) begin
					m_ticks = 0;
					m_phase = uer_pkg::PH_COUNT;
					r.done_res = echo_high_tick();
				end
			end
			default: begin
				if (tick.echo) begin
					r.done_res = echo_high_tick();
				end else begin
					latch_distance(m_ticks);
					r.done_res = 1'b1;
				end
			end
		endcase
		r.dist_value     = m_dist;
		r.digit_units    = 4'(m_dist % 10);
		r.digit_tens     = 4'((m_dist / 10) % 10);
		r.digit_hundreds = 4'((m_dist / 100) % 10);
		r.over_range     = m_over;
		r.busy_res       = (m_phase != uer_pkg::PH_IDLE);
		return r;
	endfunction

	task automatic send_tick(input logic start_req, input logic echo);
		uer_pkg::in_t tick;
		tick.start_req = start_req;
		tick.echo      = echo;
		if (gaps_on && $urandom_range(99) < 18) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 2)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= tick;
		do @(posedge clk); while (in_stall);
		if (m_phase != uer_pkg::PH_IDLE || start_req)
			live_ticks++;
		pending_outputs.push_back(next_ranger_outputs(tick));
	endtask

	task automatic drain_pipeline();
		int n;
		in_valid <= 1'b0;
		n = 0;
		while (pending_outputs.size() != 0 && n < DRAIN_LIMIT) begin
			@(posedge clk);
			n++;
		end
		repeat (PIPE_LATENCY + 2) @(posedge clk);
	endtask

	task automatic write_reg(input logic [uer_pkg::CFG_IDX_W-1:0] idx,
			input logic [uer_pkg::CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			uer_pkg::CFG_TRIGGER_TICKS: m_trig_len  = data[7:0];
			uer_pkg::CFG_MAX_COUNT:     m_max_count = data[12:0];
			uer_pkg::CFG_SCALE_Q16:     m_scale     = data;
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(input logic [15:0] trig, input logic [15:0] max_count,
			input logic [15:0] scale);
		drain_pipeline();
		write_reg(uer_pkg::CFG_TRIGGER_TICKS, trig);
		write_reg(uer_pkg::CFG_MAX_COUNT, max_count);
		write_reg(uer_pkg::CFG_SCALE_Q16, scale);
	endtask

	// Runs whatever measurement is in progress to its end.
	task automatic finish_measurement();
		while (m_phase != uer_pkg::PH_IDLE)
			send_tick(1'b0, m_phase == uer_pkg::PH_WAIT);
	endtask

	// One full measurement: start, trigger, echo low for wait_len ticks, then
	// echo high for high_len ticks. Start requests while busy are random.
	task automatic measure(input int wait_len, input int high_len);
		send_tick(1'b1, 1'($urandom_range(1)));
		while (m_phase == uer_pkg::PH_TRIG)
			send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
		repeat (wait_len)
			send_tick(1'($urandom_range(1)), 1'b0);
		repeat (high_len)
			send_tick((m_phase == uer_pkg::PH_IDLE) ? 1'b0 : 1'($urandom_range(1)), 1'b1);
		finish_measurement();
	endtask

	task automatic test_reset_defaults();
		send_tick(1'b0, 1'b0);
		send_tick(1'b0, 1'b1);
		measure(3, 25);
		measure(0, 40);
	endtask

	task automatic test_config_extremes();
		// Zero trigger length behaves as one tick.
		set_config(16'd0, 16'd1, 16'hFFFF);
		measure(2, 3);
		// Zero count limit ends on the first high echo with a zero count.
		set_config(16'd255, 16'd0, 16'hFFFF);
		measure(0, 1);
		// Largest scale: 1001 ticks scale to 1000, which is over range.
		set_config(16'd1, 16'd8191, 16'hFFFF);
		measure(1, 1001);
		set_config(16'd1, 16'd100, 16'd0);
		measure(1, 50);
		// Unused bits of a register and the unused index have no effect.
		set_config(16'hFF03, 16'hE028, 16'd40000);
		write_reg(CFG_SPARE_IDX, 16'hFFFF);
		measure(4, 60);
		measure(2, 10);
	endtask

	task automatic test_output_stall_fill();
		set_config(16'd4, 16'd200, 16'd30000);
		hold_req = 1'b1;
		measure(5, 30);
		measure(0, 12);
	endtask

	task automatic test_random_traffic();
		int          first;
		int          kind;
		int          high_len;
		int unsigned trig;
		int unsigned maxc;
		int unsigned scale;
		int unsigned pick;
		first = live_ticks;
		while (live_ticks - first < RANDOM_TICKS) begin
			// A stretch in the middle runs with no idle cycles on either side.
			gaps_on   = (live_ticks - first < 120) || (live_ticks - first >= 320);
			stalls_on = gaps_on;
			trig = ($urandom_range(99) < 75) ? $urandom_range(1, 12) : $urandom_range(0, 255);
			pick = $urandom_range(99);
			if (pick < 60)
				maxc = $urandom_range(1, 60);
			else if (pick < 85)
				maxc = $urandom_range(0, 300);
			else
				maxc = $urandom_range(0, 8191);
			scale = ($urandom_range(99) < 15) ? $urandom_range(60000, 65535)
				: $urandom_range(0, 65535);
			set_config(16'(trig | ($urandom & 32'hFF00)), 16'(maxc | ($urandom & 32'hE000)),
				16'(scale));
			repeat ($urandom_range(2, 6)) begin
				kind = $urandom_range(99);
				if (kind < 12) begin
					repeat ($urandom_range(1, 6))
						send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
					finish_measurement();
				end else begin
					high_len = $urandom_range(0, ((m_max_count < 60) ? m_max_count : 60) + 3);
					measure($urandom_range(0, 12), high_len);
				end
			end
		end
		gaps_on   = 1'b1;
		stalls_on = 1'b1;
	endtask

	// Output stall: random, or held high for a long stretch on request.
	initial begin : out_stall_gen
		int n;
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				for (n = 0; n < HOLD_CYCLES; n++) begin
					out_stall <= 1'b1;
					@(posedge clk);
				end
			end else begin
				out_stall <= stalls_on && ($urandom_range(99) < 18);
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin : check_outputs
		uer_pkg::out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_outputs.size() == 0) begin
				report_error("result transaction with nothing expected");
			end else begin
				want = pending_outputs.pop_front();
				if (out_data.trigger !== want.trigger)
					report_error($sformatf("trigger got %b want %b",
						out_data.trigger, want.trigger));
				if (out_data.done_res !== want.done_res)
					report_error($sformatf("done_res got %b want %b",
						out_data.done_res, want.done_res));
				if (out_data.dist_value !== want.dist_value)
					report_error($sformatf("dist_value got %0d want %0d",
						out_data.dist_value, want.dist_value));
				if (out_data.digit_units !== want.digit_units)
					report_error($sformatf("digit_units got %0d want %0d",
						out_data.digit_units, want.digit_units));
				if (out_data.digit_tens !== want.digit_tens)
					report_error($sformatf("digit_tens got %0d want %0d",
						out_data.digit_tens, want.digit_tens));
				if (out_data.digit_hundreds !== want.digit_hundreds)
					report_error($sformatf("digit_hundreds got %0d want %0d",
						out_data.digit_hundreds, want.digit_hundreds));
				if (out_data.over_range !== want.over_range)
					report_error($sformatf("over_range got %b want %b",
						out_data.over_range, want.over_range));
				if (out_data.busy_res !== want.busy_res)
					report_error($sformatf("busy_res got %b want %b",
						out_data.busy_res, want.busy_res));
			end
		end
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("ultrasonic_echo_ranger_core test failed");
		$finish;
	end

	initial begin
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		in_data   <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_config_extremes();
		test_output_stall_fill();
		test_random_traffic();
		drain_pipeline();
		if (pending_outputs.size() != 0)
			report_error($sformatf("%0d expected results never arrived",
				pending_outputs.size()));
		if (error_count == 0)
			$display("ultrasonic_echo_ranger_core test passed");
		else
			$display("ultrasonic_echo_ranger_core test failed");
		$finish;
	end

endmodule
